### rtl/core/adbd_pkg.sv
// Shared types, constants and tables of the audio delay, bitcrush and downsample core.
package adbd_pkg;

    // Delay store geometry.
    localparam int STORE_DEPTH = 1536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the stream words.
    localparam int SAMPLE_W  = 8;
    localparam int DELAY_W   = 11;
    localparam int FB_SEL_W  = 3;
    localparam int LEVEL_W   = 8;
    localparam int HOLD_W    = 5;
    localparam int STEP_W    = 6;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_EN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOWNSAMPLE_EN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BITCRUSH_EN   = 2'd2;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_WRITE
    } adbd_state_t;

    // Feedback ratio: numerator over two to the power of log2den.
    typedef struct packed {
        logic [2:0] num;
        logic [1:0] log2den;
    } ratio_t;

    // Request to the serial remainder unit.
    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] dividend;
        logic [STEP_W-1:0]   divisor;
    } div_req_t;

    // Answer of the serial remainder unit.
    typedef struct packed {
        logic                done;
        logic [HOLD_W-1:0]   rem;
    } div_rsp_t;

    // Fixed feedback ratios for the eight selector values.
    function automatic ratio_t fb_ratio(input logic [FB_SEL_W-1:0] sel);
        ratio_t r;
        case (sel)
            3'd0:    r = '{num: 3'd0, log2den: 2'd0};
            3'd1:    r = '{num: 3'd1, log2den: 2'd2};
            3'd2:    r = '{num: 3'd1, log2den: 2'd2};
            3'd3:    r = '{num: 3'd1, log2den: 2'd1};
            3'd4:    r = '{num: 3'd1, log2den: 2'd1};
            3'd5:    r = '{num: 3'd1, log2den: 2'd1};
            3'd6:    r = '{num: 3'd3, log2den: 2'd2};
            default: r = '{num: 3'd7, log2den: 2'd3};
        endcase
        return r;
    endfunction

endpackage

### rtl/core/adbd_crush_div.sv
// Bit-serial restoring remainder unit used to quantise the output sample.
module adbd_crush_div
    import adbd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(SAMPLE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HOLD_W-1:0]   rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dvd_reg, dvd_next;
    logic [STEP_W-1:0]   dvs_reg, dvs_next;
    logic [STEP_W-1:0]   trial;

    // One quotient bit a cycle: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[SAMPLE_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= dvs_reg) begin
                rem_next = HOLD_W'(trial - dvs_reg);
            end else begin
                rem_next = HOLD_W'(trial);
            end
            dvd_next = {dvd_reg[SAMPLE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/core/audio_delay_bitcrush_downsample_core.sv
// Top level of the feedback delay line with sample-and-hold downsampler and bitcrusher.
//
//  Channel   Direction  Contents
//  s_axis    in         one sample with its knob values per word
//  m_axis    out        one processed sample per accepted input word
//  cfg       in         delay, downsample and bitcrush enables
//
// Each word passes from acceptance to result through these steps: the remainder
// unit is started, the remainder is formed bit-serially, it is subtracted from
// the sample, and the result is written back. The store is read at the accepting
// edge. s_tready is low from acceptance to write-back, so a new word is not taken
// until the last one is written back. After reset the delay store is cleared
// one entry a cycle, and no word is accepted meanwhile. A stalled output holds
// the write-back stage.
module audio_delay_bitcrush_downsample_core
    import adbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] sample_in, [18:8] delay_setting, [21:19] feedback_select,
    // [29:22] downsample_level, [37:30] bitcrush_level, [39:38] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] sample_out
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic                  cfg_wdata
);

    adbd_state_t state_reg, state_next;

    // Configuration.
    logic delay_en_reg, ds_en_reg, bc_en_reg;

    // Sequencer and delay state.
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [ADDR_W-1:0]   delay_reg, delay_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;

    // Per-word payload.
    logic [DELAY_W-1:0]  req_reg;
    logic [FB_SEL_W-1:0] sel_reg;
    logic [LEVEL_W-1:0]  bc_level_reg;
    logic [SAMPLE_W-1:0] res_reg, res_next;
    logic [SAMPLE_W-1:0] crush_reg, crush_next;

    // Store ports.
    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;

    logic                s_fire, wb_fire;
    logic [SAMPLE_W-1:0] sample_in;
    ratio_t              ratio;
    logic [3:0]          in_num;
    logic [10:0]         out_part;
    logic [11:0]         in_part;
    logic [SAMPLE_W-1:0] blend;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign sample_in = s_tdata[7:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign wb_fire   = (state_reg == ST_WRITE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Read position trails the write position by the active delay, modulo the depth.
    always_comb begin
        if (wp_reg >= delay_reg) begin
            rd_addr = wp_reg - delay_reg;
        end else begin
            rd_addr = ADDR_W'(32'(wp_reg) + STORE_DEPTH - 32'(delay_reg));
        end
    end

    // Feedback blend of the quantised output with the held sample.
    always_comb begin
        ratio    = fb_ratio(sel_reg);
        in_num   = 4'((5'd1 << ratio.log2den) - 5'(ratio.num));
        out_part = (11'(crush_reg) * 11'(ratio.num)) >> ratio.log2den;
        in_part  = (12'(held_reg) * 12'(in_num)) >> ratio.log2den;
        blend    = SAMPLE_W'(out_part) + SAMPLE_W'(in_part);
    end

    // Serial remainder unit for the bitcrusher.
    adbd_crush_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer: clear pass, accept, select, divide, write back.
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        wp_next        = wp_reg;
        delay_next     = delay_reg;
        hold_next      = hold_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        res_next       = res_reg;
        crush_next     = crush_reg;
        wr_en          = 1'b0;
        wr_addr        = wp_reg;
        wr_data        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = (delay_reg == '0) ? held_reg : rd_data_reg;
        div_req.divisor  = bc_en_reg ? STEP_W'({1'b0, bc_level_reg[7:3]} + 6'd1)
                                     : STEP_W'(1);

        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (hold_reg == '0) begin
                        held_next = sample_in;
                        hold_next = ds_en_reg ? s_tdata[29:25] : '0;
                    end else begin
                        hold_next = hold_reg - 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                div_req.start = 1'b1;
                res_next      = div_req.dividend;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    crush_next = res_reg - SAMPLE_W'(div_rsp.rem);
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (wb_fire) begin
                    wr_en          = 1'b1;
                    wr_data        = delay_en_reg ? blend : crush_reg;
                    out_valid_next = 1'b1;
                    out_data_next  = crush_reg;
                    if (!delay_en_reg) begin
                        delay_next = '0;
                    end else if (32'(req_reg) > STORE_DEPTH - 1) begin
                        delay_next = ADDR_W'(STORE_DEPTH - 1);
                    end else begin
                        delay_next = ADDR_W'(req_reg);
                    end
                    wp_next = (wp_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and delay state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            wp_reg        <= '0;
            delay_reg     <= '0;
            hold_reg      <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_addr_reg  <= clr_addr_next;
            wp_reg        <= wp_next;
            delay_reg     <= delay_next;
            hold_reg      <= hold_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_en_reg <= 1'b0;
            ds_en_reg    <= 1'b0;
            bc_en_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DELAY_EN:      delay_en_reg <= cfg_wdata;
                CFG_DOWNSAMPLE_EN: ds_en_reg    <= cfg_wdata;
                CFG_BITCRUSH_EN:   bc_en_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        crush_reg    <= crush_next;
        if (s_fire) begin
            req_reg      <= s_tdata[18:8];
            sel_reg      <= s_tdata[21:19];
            bc_level_reg <= s_tdata[37:30];
        end
    end

    // Delay store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (s_fire) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // The active delay always stays inside the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(delay_reg) <= STORE_DEPTH - 1)
        else $error("active delay beyond store depth");

    // The write position always stays inside the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wp_reg) <= STORE_DEPTH - 1)
        else $error("write position beyond store depth");

    // An accepted word moves straight on to the select cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_LOAD)
        else $error("accepted word not taken into the sequencer");

    // Write-back waits while a finished result is still unclaimed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && out_valid_reg && !m_tready)
            |=> (state_reg == ST_WRITE && $stable(wp_reg)))
        else $error("write-back overran a stalled result");

    // The remainder unit answers only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("remainder answer outside the divide state");

endmodule
